FILE: rtl/fdd_pkg.sv
`default_nettype none

package fdd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int DERIV_WIDTH  = 23;
    localparam int QUEUE_DEPTH  = 4;
    localparam int SEEN_WIDTH   = 3;
    localparam int WINDOW_TAPS  = 5;

    localparam logic [SEEN_WIDTH-1:0] SEEN_PAIR = 3'd3;
    localparam logic [SEEN_WIDTH-1:0] SEEN_MID  = 3'd4;
    localparam logic [SEEN_WIDTH-1:0] SEEN_MAX  = 3'd5;

    localparam int OUT_MAX = 4194303;
    localparam int OUT_MIN = -4194304;

    // What one accepted sample asks of the back end.
    typedef struct packed {
        logic is_short;
        logic pair;
        logic mid;
        logic end_seq;
    } t_job_flags;

    typedef enum logic [2:0] {
        OP_FIRST,
        OP_SECOND,
        OP_MID,
        OP_PENULT,
        OP_FINAL,
        OP_SHORT
    } t_op;

endpackage

`default_nettype wire

FILE: rtl/fdd_queue.sv
`default_nettype none

module fdd_queue #(
    parameter int DATA_W = 84,
    parameter int DEPTH  = fdd_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fdd_front.sv
`default_nettype none

module fdd_front #(
    parameter int SAMPLE_WIDTH = fdd_pkg::SAMPLE_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                    i_end_of_sequence,
    input  wire logic                    i_full,
    output logic                         o_push,
    output fdd_pkg::t_job_flags          o_flags,
    output logic [fdd_pkg::WINDOW_TAPS-1:0][SAMPLE_WIDTH-1:0] o_window
);

    localparam int TAPS = fdd_pkg::WINDOW_TAPS;

    // Previous samples, index 0 is the oldest.
    logic [TAPS-2:0][SAMPLE_WIDTH-1:0] r_hist;
    logic [fdd_pkg::SEEN_WIDTH-1:0]    r_seen;
    logic                              accept;
    logic                              is_short;

    assign o_ready  = !i_full;
    assign accept   = i_valid && !i_full;

    always_comb begin
        for (int k = 0; k < TAPS - 1; k++) begin
            o_window[k] = r_hist[k];
        end
        o_window[TAPS-1] = i_sample;
    end

    assign is_short        = i_end_of_sequence && (r_seen < fdd_pkg::SEEN_PAIR);
    assign o_flags.is_short = is_short;
    assign o_flags.pair     = !is_short && (r_seen == fdd_pkg::SEEN_PAIR);
    assign o_flags.mid      = !is_short && (r_seen >= fdd_pkg::SEEN_MID);
    assign o_flags.end_seq  = i_end_of_sequence && !is_short;
    assign o_push = accept && (o_flags.is_short || o_flags.pair || o_flags.mid);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < TAPS - 1; k++) begin
                r_hist[k] <= o_window[k+1];
            end
        end
    end

    // The sample count restarts after every end mark; stale window contents are
    // never read because a stencil needs at least four fresh samples.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (accept) begin
            if (i_end_of_sequence) begin
                r_seen <= '0;
            end else if (r_seen < fdd_pkg::SEEN_MAX) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fdd_back.sv
`default_nettype none

module fdd_back #(
    parameter int SAMPLE_WIDTH = fdd_pkg::SAMPLE_WIDTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_job_valid,
    input  wire fdd_pkg::t_job_flags    i_flags,
    input  wire logic [fdd_pkg::WINDOW_TAPS-1:0][SAMPLE_WIDTH-1:0] i_window,
    output logic                        o_pop,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [fdd_pkg::DERIV_WIDTH-1:0] o_derivative_x12,
    output logic                        o_last_result,
    output logic                        o_too_short
);

    localparam int DW    = fdd_pkg::DERIV_WIDTH;
    localparam int TAPS  = fdd_pkg::WINDOW_TAPS;
    // Stencil coefficients sum to at most 80 in magnitude.
    localparam int ACC_W = SAMPLE_WIDTH + 8;
    localparam int SAT_W = (ACC_W > DW) ? ACC_W : DW;
    localparam logic signed [SAT_W-1:0] LIM_MAX = SAT_W'(fdd_pkg::OUT_MAX);
    localparam logic signed [SAT_W-1:0] LIM_MIN = SAT_W'(fdd_pkg::OUT_MIN);

    logic [1:0]              r_sub;
    logic [1:0]              last_sub;
    logic                    load;
    logic                    last_op;
    fdd_pkg::t_op            op;
    logic signed [ACC_W-1:0] w [TAPS];
    logic signed [ACC_W-1:0] acc;
    logic signed [SAT_W-1:0] acc_x;
    logic signed [SAT_W-1:0] sat;

    logic                    r_valid;
    logic [DW-1:0]           r_deriv;
    logic                    r_last;
    logic                    r_short;

    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            w[k] = ACC_W'($signed(i_window[k]));
        end
    end

    // Order of results for one job: forward pair or centered value, then the
    // backward pair if the sequence ends there; a short job has one result.
    always_comb begin
        op       = fdd_pkg::OP_SHORT;
        last_sub = 2'd0;
        if (i_flags.is_short) begin
            op       = fdd_pkg::OP_SHORT;
            last_sub = 2'd0;
        end else if (i_flags.pair) begin
            last_sub = i_flags.end_seq ? 2'd3 : 2'd1;
            unique case (r_sub)
                2'd0:    op = fdd_pkg::OP_FIRST;
                2'd1:    op = fdd_pkg::OP_SECOND;
                2'd2:    op = fdd_pkg::OP_PENULT;
                default: op = fdd_pkg::OP_FINAL;
            endcase
        end else begin
            last_sub = i_flags.end_seq ? 2'd2 : 2'd0;
            unique case (r_sub)
                2'd0:    op = fdd_pkg::OP_MID;
                2'd1:    op = fdd_pkg::OP_PENULT;
                default: op = fdd_pkg::OP_FINAL;
            endcase
        end
    end

    always_comb begin
        unique case (op)
            fdd_pkg::OP_FIRST:
                acc = -(w[1] <<< 4) - (w[1] <<< 2) - (w[1] <<< 1)
                      + (w[2] <<< 5) + (w[2] <<< 2)
                      - (w[3] <<< 4) - (w[3] <<< 1)
                      + (w[4] <<< 2);
            fdd_pkg::OP_SECOND:
                acc = -(w[1] <<< 2)
                      - (w[2] <<< 2) - (w[2] <<< 1)
                      + (w[3] <<< 3) + (w[3] <<< 2)
                      - (w[4] <<< 1);
            fdd_pkg::OP_MID:
                acc = w[0] - (w[1] <<< 3) + (w[3] <<< 3) - w[4];
            fdd_pkg::OP_PENULT:
                acc = (w[1] <<< 1)
                      - (w[2] <<< 3) - (w[2] <<< 2)
                      + (w[3] <<< 2) + (w[3] <<< 1)
                      + (w[4] <<< 2);
            fdd_pkg::OP_FINAL:
                acc = -(w[1] <<< 2)
                      + (w[2] <<< 4) + (w[2] <<< 1)
                      - (w[3] <<< 5) - (w[3] <<< 2)
                      + (w[4] <<< 4) + (w[4] <<< 2) + (w[4] <<< 1);
            default:
                acc = '0;
        endcase
    end

    assign acc_x = SAT_W'(acc);

    always_comb begin
        priority if (acc_x > LIM_MAX) begin
            sat = LIM_MAX;
        end else if (acc_x < LIM_MIN) begin
            sat = LIM_MIN;
        end else begin
            sat = acc_x;
        end
    end

    assign load    = i_job_valid && (!r_valid || i_ready);
    assign last_op = (r_sub == last_sub);
    assign o_pop   = load && last_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= last_op ? 2'd0 : r_sub + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_deriv <= sat[DW-1:0];
            r_last  <= (op == fdd_pkg::OP_FINAL) || (op == fdd_pkg::OP_SHORT);
            r_short <= (op == fdd_pkg::OP_SHORT);
        end
    end

    assign o_valid          = r_valid;
    assign o_derivative_x12 = r_deriv;
    assign o_last_result    = r_last;
    assign o_too_short      = r_short;

endmodule

`default_nettype wire

FILE: rtl/finite_difference_derivative_unit.sv
`default_nettype none
// A sample's results pass through the job queue and then the back end's output register.
// Throughput: one sample per cycle, and one result per cycle while the receiver is ready;
// an end mark adds up to two extra results, drained by the back end while the 4-entry job
// queue absorbs input. Input stalls only when that queue is full.
// Reset (synchronous, active low) empties the queue, the output register and the count.

module finite_difference_derivative_unit #(
    parameter int SAMPLE_WIDTH = fdd_pkg::SAMPLE_WIDTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] i_sample,
    input  wire logic                    i_end_of_sequence,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [fdd_pkg::DERIV_WIDTH-1:0] o_derivative_x12,
    output logic                         o_last_result,
    output logic                         o_too_short
);

    localparam int TAPS   = fdd_pkg::WINDOW_TAPS;
    localparam int FLAG_W = $bits(fdd_pkg::t_job_flags);
    localparam int WIN_W  = TAPS * SAMPLE_WIDTH;
    localparam int DATA_W = FLAG_W + WIN_W;

    fdd_pkg::t_job_flags                 front_flags;
    fdd_pkg::t_job_flags                 back_flags;
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0]   front_window;
    logic [TAPS-1:0][SAMPLE_WIDTH-1:0]   back_window;
    logic                                push;
    logic                                full;
    logic                                pop;
    logic                                job_valid;
    logic [DATA_W-1:0]                   q_in;
    logic [DATA_W-1:0]                   q_out;

    fdd_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_sample         (i_sample),
        .i_end_of_sequence(i_end_of_sequence),
        .i_full           (full),
        .o_push           (push),
        .o_flags          (front_flags),
        .o_window         (front_window)
    );

    assign q_in = {front_flags, front_window};

    fdd_queue #(
        .DATA_W(DATA_W),
        .DEPTH (fdd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (q_in),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(job_valid),
        .o_data (q_out)
    );

    assign back_flags  = q_out[DATA_W-1:WIN_W];
    assign back_window = q_out[WIN_W-1:0];

    fdd_back #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (job_valid),
        .i_flags         (back_flags),
        .i_window        (back_window),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_derivative_x12(o_derivative_x12),
        .o_last_result   (o_last_result),
        .o_too_short     (o_too_short)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
module tb_top;

    localparam int STALL_LIMIT     = 1000;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 8;
    localparam int ITEMS_PER_PHASE = 55;

    typedef struct packed {
        logic signed [fdd_pkg::DERIV_WIDTH-1:0] deriv;
        logic                                   last;
        logic                                   too_short;
    } t_deriv_beat;

    typedef struct {
        logic [fdd_pkg::SAMPLE_WIDTH-1:0] smp;
        logic                             eos;
        bit                               typed;
        t_deriv_beat                      want;
    } t_stim_row;

    localparam t_deriv_beat SHORT_BEAT = '{deriv: '0, last: 1'b1, too_short: 1'b1};
    localparam t_deriv_beat FLAT_BEAT  = '{deriv: '0, last: 1'b0, too_short: 1'b0};

    logic                             i_clk             = 1'b0;
    logic                             i_rst_n           = 1'b0;
    logic                             i_valid           = 1'b0;
    logic [fdd_pkg::SAMPLE_WIDTH-1:0] i_sample          = '0;
    logic                             i_end_of_sequence = 1'b0;
    logic                             i_ready           = 1'b0;
    logic                             o_ready;
    logic                             o_valid;
    logic [fdd_pkg::DERIV_WIDTH-1:0]  o_derivative_x12;
    logic                             o_last_result;
    logic                             o_too_short;

    int          n_errors    = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    logic        hold_req    = 1'b0;
    logic        hold_ack    = 1'b0;
    int          hold_left   = 0;
    int          quiet_cycles = 0;

    // Predictor state: five-sample window (oldest first) and saturating count.
    int          win [fdd_pkg::WINDOW_TAPS];
    int          n_seen = 0;
    t_deriv_beat expected_beats [$];

    // Directed stimulus. Typed rows hold the one beat they must produce.
    t_stim_row directed_rows [22] = '{
        '{16'h0000, 1'b1, 1'b1, SHORT_BEAT},
        '{16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b1, 1'b1, SHORT_BEAT},
        '{16'h0001, 1'b0, 1'b0, '0},
        '{16'h0002, 1'b0, 1'b0, '0},
        '{16'h0003, 1'b1, 1'b1, SHORT_BEAT},
        '{16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h7FFF, 1'b0, 1'b1, FLAT_BEAT},
        '{16'h7FFF, 1'b1, 1'b0, '0},
        '{16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b0, 1'b0, '0},
        '{16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b0, 1'b0, '0},
        '{16'h7FFF, 1'b0, 1'b0, '0},
        '{16'h8000, 1'b1, 1'b0, '0},
        '{16'h0064, 1'b0, 1'b0, '0},
        '{16'hFF38, 1'b0, 1'b0, '0},
        '{16'h012C, 1'b0, 1'b0, '0},
        '{16'hFE70, 1'b1, 1'b0, '0}
    };

    finite_difference_derivative_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .i_end_of_sequence (i_end_of_sequence),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_derivative_x12  (o_derivative_x12),
        .o_last_result     (o_last_result),
        .o_too_short       (o_too_short)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_deriv_beat make_beat(input int v, input logic last, input logic ts);
        t_deriv_beat b;
        if (v > fdd_pkg::OUT_MAX) v = fdd_pkg::OUT_MAX;
        if (v < fdd_pkg::OUT_MIN) v = fdd_pkg::OUT_MIN;
        b.deriv     = v[fdd_pkg::DERIV_WIDTH-1:0];
        b.last      = last;
        b.too_short = ts;
        return b;
    endfunction

    // Four-point stencil over the newest four samples, oldest coefficient first.
    function automatic int four_tap(input int c0, input int c1, input int c2, input int c3);
        return c0 * win[1] + c1 * win[2] + c2 * win[3] + c3 * win[4];
    endfunction

    function automatic void clear_window();
        for (int i = 0; i < fdd_pkg::WINDOW_TAPS; i++) win[i] = 0;
        n_seen = 0;
    endfunction

    function automatic void predict_derivatives(input logic [fdd_pkg::SAMPLE_WIDTH-1:0] smp,
                                                input logic eos);
        int prior;
        prior = n_seen;
        for (int i = 0; i < fdd_pkg::WINDOW_TAPS - 1; i++) win[i] = win[i+1];
        win[fdd_pkg::WINDOW_TAPS-1] = int'(signed'(smp));
        if (n_seen < int'(fdd_pkg::SEEN_MAX)) n_seen++;
        if (eos && prior < int'(fdd_pkg::SEEN_PAIR)) begin
            expected_beats.push_back(make_beat(0, 1'b1, 1'b1));
            clear_window();
            return;
        end
        if (prior == int'(fdd_pkg::SEEN_PAIR)) begin
            expected_beats.push_back(make_beat(four_tap(-22, 36, -18, 4), 1'b0, 1'b0));
            expected_beats.push_back(make_beat(four_tap(-4, -6, 12, -2), 1'b0, 1'b0));
        end
        if (prior >= int'(fdd_pkg::SEEN_MID))
            expected_beats.push_back(make_beat(win[0] - 8 * win[1] + 8 * win[3] - win[4],
                                               1'b0, 1'b0));
        if (eos) begin
            expected_beats.push_back(make_beat(four_tap(2, -12, 6, 4), 1'b0, 1'b0));
            expected_beats.push_back(make_beat(four_tap(-4, 18, -36, 22), 1'b1, 1'b0));
            clear_window();
        end
    endfunction

    function automatic logic [fdd_pkg::SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return fdd_pkg::SAMPLE_WIDTH'($urandom_range(16) - 8);
            default: return fdd_pkg::SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 15) return $urandom_range(1, 3);
        if (r < 90) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    task automatic send_sample(input logic [fdd_pkg::SAMPLE_WIDTH-1:0] smp, input logic eos,
                               input bit typed, input t_deriv_beat want);
        int n_queued;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_sample          <= smp;
        i_end_of_sequence <= eos;
        do @(posedge i_clk); while (!o_ready);
        n_queued = expected_beats.size();
        predict_derivatives(smp, eos);
        if (typed) begin
            while (expected_beats.size() > n_queued) void'(expected_beats.pop_back());
            expected_beats.push_back(want);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input bit long_hold);
        int sent;
        int len;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        if (long_hold) hold_req <= ~hold_req;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
            len = pick_length();
            for (int k = 0; k < len; k++) send_sample(pick_sample(), k == len - 1, 1'b0, '0);
            sent += len;
        end
        wait_drained();
    endtask

    task automatic check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
            n_errors++;
        end
    endtask

    // Receiver: random stalls, plus one long hold-off started from the stimulus side.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            hold_left <= 0;
            hold_ack  <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_deriv_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got %0d last %b too_short %b",
                         $time, int'(signed'(o_derivative_x12)), o_last_result, o_too_short);
                n_errors++;
            end else begin
                want = expected_beats.pop_front();
                check_field("derivative_x12", int'(signed'(want.deriv)),
                            int'(signed'(o_derivative_x12)));
                check_field("last_result", int'(want.last), int'(o_last_result));
                check_field("too_short", int'(want.too_short), int'(o_too_short));
            end
        end
    end

    // A stall with no beat moving on either side for too long ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_window();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        tx_idle_pct = 26;
        rx_idle_pct <= 72;
        @(posedge i_clk);
        for (int r = 0; r < 22; r++)
            send_sample(directed_rows[r].smp, directed_rows[r].eos,
                        directed_rows[r].typed, directed_rows[r].want);
        wait_drained();
        run_phase(26, 72, 1'b0);
        run_phase(72, 26, 1'b0);
        // No idling here, so the hold-off backs the block up into its input.
        run_phase(0, 0, 1'b1);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && expected_beats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: files.f
rtl/fdd_pkg.sv
rtl/fdd_queue.sv
rtl/fdd_front.sv
rtl/fdd_back.sv
rtl/finite_difference_derivative_unit.sv
sim/tb_top.sv
